// File: sv/ssi_encoder_frame_receiver_macros.svh
// Assertion macros used by the frame receiver checker.
`ifndef SSI_ENCODER_FRAME_RECEIVER_MACROS_SVH
`define SSI_ENCODER_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SEFR_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SEFR_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/sefr_pkg.sv
// Types and constants of the SSI encoder frame receiver.
`default_nettype none
package sefr_pkg;

    // Register reset values and saturation limits
    localparam logic [4:0] MT_RESET  = 5'd12;
    localparam logic [4:0] ST_RESET  = 5'd13;
    localparam logic [3:0] CRC_RESET = 4'd6;
    localparam logic [4:0] MT_MAX    = 5'd24;
    localparam logic [4:0] ST_MAX    = 5'd30;
    localparam logic [3:0] CRC_MAX   = 4'd8;

    // Warning and error bits of the frame, one each
    localparam int WARNING_BITS = 1;
    localparam int ERROR_BITS   = 1;
    localparam int STATUS_BITS  = WARNING_BITS + ERROR_BITS;

    // Field widths
    localparam int FRAME_W = 64;
    localparam int CNT_W   = 7;
    localparam int MT_W    = 24;
    localparam int ST_W    = 30;
    localparam int CRC_W   = 8;
    localparam int OUT_W   = 128;
    localparam int IN_W    = 8;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Completed-frame queue depth
    localparam int QUEUE_DEPTH_DEF = 2;

    // Item kinds carried on tuser
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_DATA  = 1'b1;

    // Register index (paddr[3:2])
    typedef enum logic [1:0] {
        REG_MT  = 2'd0,
        REG_ST  = 2'd1,
        REG_CRC = 2'd2
    } cfg_reg_t;

    // Saturated field widths from the register file
    typedef struct packed {
        logic [4:0] mt;
        logic [4:0] st;
        logic [3:0] cb;
    } cfg_widths_t;

    // One completed frame waiting for field extraction
    typedef struct packed {
        logic [FRAME_W-1:0] raw;
        cfg_widths_t        w;
    } frame_entry_t;

endpackage
`default_nettype wire

// File: sv/sefr_cfg.sv
// APB register file holding the frame field widths.
`default_nettype none
module sefr_cfg
    import sefr_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output cfg_widths_t             widths
);

    logic [4:0] mt_reg, mt_next;
    logic [4:0] st_reg, st_next;
    logic [3:0] cb_reg, cb_next;
    logic       wr_en;
    cfg_reg_t   idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = cfg_reg_t'(paddr[3:2]);

    // Write decode
    always_comb begin
        mt_next = mt_reg;
        st_next = st_reg;
        cb_next = cb_reg;
        if (wr_en) begin
            unique case (idx)
                REG_MT:  mt_next = pwdata[4:0];
                REG_ST:  st_next = pwdata[4:0];
                REG_CRC: cb_next = pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mt_reg <= MT_RESET;
            st_reg <= ST_RESET;
            cb_reg <= CRC_RESET;
        end else begin
            mt_reg <= mt_next;
            st_reg <= st_next;
            cb_reg <= cb_next;
        end
    end

    // Read mux returns the stored value
    always_comb begin
        unique case (idx)
            REG_MT:  prdata = {27'd0, mt_reg};
            REG_ST:  prdata = {27'd0, st_reg};
            REG_CRC: prdata = {28'd0, cb_reg};
            default: prdata = '0;
        endcase
    end

    // Saturate so a frame never exceeds 64 bits
    assign widths.mt = (mt_reg > MT_MAX)  ? MT_MAX  : mt_reg;
    assign widths.st = (st_reg > ST_MAX)  ? ST_MAX  : st_reg;
    assign widths.cb = (cb_reg > CRC_MAX) ? CRC_MAX : cb_reg;

endmodule
`default_nettype wire

// File: sv/sefr_front.sv
// Front end: takes bit transactions, shifts the frame, detects frame end.
`default_nettype none
module sefr_front
    import sefr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    input  wire logic        in_kind,
    input  wire logic        in_bit,
    input  wire logic        q_full,
    input  wire cfg_widths_t widths,
    output logic             in_ready,
    output logic             push,
    output frame_entry_t     push_entry
);

    logic [FRAME_W-1:0] shift_reg, shift_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               active_reg, active_next;
    logic [CNT_W-1:0]   len;
    logic               accept;

    assign in_ready = ~q_full;
    assign accept   = in_valid & in_ready;

    // Frame length in bits, at most 64
    assign len = CNT_W'(widths.mt) + CNT_W'(widths.st) + CNT_W'(widths.cb)
               + CNT_W'(STATUS_BITS);

    // Start clears, data shifts in while armed
    always_comb begin
        shift_next  = shift_reg;
        cnt_next    = cnt_reg;
        active_next = active_reg;
        push        = 1'b0;
        if (accept) begin
            if (in_kind == KIND_START) begin
                shift_next  = '0;
                cnt_next    = '0;
                active_next = 1'b1;
            end else if (active_reg) begin
                shift_next = {shift_reg[FRAME_W-2:0], in_bit};
                if (cnt_reg != CNT_W'(FRAME_W)) begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (cnt_next >= len) begin
                    push        = 1'b1;
                    active_next = 1'b0;
                end
            end
        end
    end

    // Keep only the last len bits; a shift by 64 gives an all-ones mask
    assign push_entry.raw = shift_next & ~({FRAME_W{1'b1}} << len);
    assign push_entry.w   = widths;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            active_reg <= 1'b0;
        end else begin
            cnt_reg    <= cnt_next;
            active_reg <= active_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
    end

endmodule
`default_nettype wire

// File: sv/sefr_queue.sv
// Short queue of completed frames between front and back end.
`default_nettype none
module sefr_queue
    import sefr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire frame_entry_t push_entry,
    input  wire logic         pop,
    output logic              full,
    output logic              not_empty,
    output frame_entry_t      head
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    frame_entry_t   mem [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;

    assign full      = (cnt_reg == CW'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        priority if (push && !pop) cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)     cnt_next = cnt_reg - 1'b1;
        else                       cnt_next = cnt_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

// File: sv/sefr_back.sv
// Back end: splits a completed frame into its fields, output register.
`default_nettype none
module sefr_back
    import sefr_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         q_valid,
    input  wire frame_entry_t q_head,
    input  wire logic         out_ready,
    output logic              pop,
    output logic              out_valid,
    output logic [OUT_W-1:0]  out_data
);

    logic             valid_reg, valid_next;
    logic [OUT_W-1:0] data_reg, data_next;
    logic [CNT_W-1:0] lo_st, lo_mt;
    logic [FRAME_W-1:0] sh_err, sh_st, sh_mt;
    logic [MT_W-1:0]  mt_val;
    logic [ST_W-1:0]  st_val;
    logic [CRC_W-1:0] crc_val;

    assign pop = q_valid & (~valid_reg | out_ready);

    // Field positions counted from the last received bit
    assign lo_st  = CNT_W'(q_head.w.cb) + CNT_W'(STATUS_BITS);
    assign lo_mt  = lo_st + CNT_W'(q_head.w.st);
    assign sh_err = q_head.raw >> q_head.w.cb;
    assign sh_st  = q_head.raw >> lo_st;
    assign sh_mt  = q_head.raw >> lo_mt;

    assign mt_val  = sh_mt[MT_W-1:0] & ~({MT_W{1'b1}} << q_head.w.mt);
    assign st_val  = sh_st[ST_W-1:0] & ~({ST_W{1'b1}} << q_head.w.st);
    assign crc_val = q_head.raw[CRC_W-1:0] & ~({CRC_W{1'b1}} << q_head.w.cb);

    // Output register load and release; warning sits above error in the frame
    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (pop) begin
            valid_next = 1'b1;
            data_next  = {q_head.raw, crc_val, sh_err[0], sh_err[1], st_val, mt_val};
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

// File: sv/ssi_encoder_frame_receiver.sv
// Top level of the SSI encoder frame receiver.
//
//  Channel  | Direction | Payload
//  ---------+-----------+--------------------------------------------------
//  s_       | in        | tuser[0] kind, tdata[0] line_bit
//  m_       | out       | tdata: multiturn, singleturn, warning, error, crc, raw
//  APB      | in/out    | field widths at 0x0, 0x4, 0x8
//
// One bit transaction per cycle while s_tready is high. The transaction
// carrying the last frame bit writes the frame into the queue, and the
// field-extraction register loads the result from there once it is free.
// s_tready drops only when the completed-frame queue is full (QUEUE_DEPTH
// frames waiting on m_tready). Reset is synchronous; there is no clearing pass.
`default_nettype none
module ssi_encoder_frame_receiver
    import sefr_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [IN_W-1:0]    s_tdata,   // [0] line_bit, [7:1] zero
    input  wire logic [0:0]         s_tuser,   // [0] kind
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // [23:0] multiturn_value, [53:24] singleturn_value, [54] warning_flag,
    // [55] error_flag, [63:56] crc_value, [127:64] raw_frame
    output logic      [OUT_W-1:0]   m_tdata,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    cfg_widths_t  widths;
    logic         push, pop, q_full, q_valid;
    frame_entry_t push_entry, q_head;

    // Register file
    sefr_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .widths  (widths)
    );

    // Bit intake
    sefr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_kind    (s_tuser[0]),
        .in_bit     (s_tdata[0]),
        .q_full     (q_full),
        .widths     (widths),
        .in_ready   (s_tready),
        .push       (push),
        .push_entry (push_entry)
    );

    // Completed frames
    sefr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .not_empty  (q_valid),
        .head       (q_head)
    );

    // Field extraction and result
    sefr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .out_ready (m_tready),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_data  (m_tdata)
    );

endmodule
`default_nettype wire

// File: sv/sefr_checker.sv
// Port-level checks of the frame receiver, bound to the top level.
`default_nettype none
`include "ssi_encoder_frame_receiver_macros.svh"
module sefr_checker
    import sefr_pkg::*;
(
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [OUT_W-1:0]   m_tdata,
    input wire logic               psel,
    input wire logic               penable,
    input wire logic               pwrite,
    input wire logic [PADDR_W-1:0] paddr,
    input wire logic [PDATA_W-1:0] pwdata,
    input wire logic [PDATA_W-1:0] prdata,
    input wire logic               pready
);

    logic mt_wr, mt_rd;

    // Multiturn register write and read accesses
    assign mt_wr = psel && penable && pwrite && (paddr[3:2] == REG_MT);
    assign mt_rd = psel && !pwrite && (paddr[3:2] == REG_MT);

    // A stalled result stays offered
    `SEFR_CHECK_NEXT(a_m_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

    // A stalled result keeps its payload
    `SEFR_CHECK_NEXT(a_m_stable, m_tvalid && !m_tready, $stable(m_tdata), "stalled result changed")

    // Register port never inserts wait states
    `SEFR_CHECK(a_pready, 1'b1, pready, "pready low")

    // A multiturn width write reads back masked on the next access
    `SEFR_CHECK(a_readback, mt_wr ##1 mt_rd, prdata == PDATA_W'($past(pwdata[4:0])), "readback")

endmodule

bind ssi_encoder_frame_receiver sefr_checker u_sefr_checker (.*);
`default_nettype wire
